/* rtl/swraddr_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the
// sine-wave row warp address unit. No dependencies.
`default_nettype none

package swraddr_pkg;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd3;

	localparam int CFG_DATA_W = 24;

	// Register reset values
	localparam logic [23:0] PHASE_STEP_RST      = 24'd129052;
	localparam logic [12:0] FRAME_HEIGHT_RST    = 13'd480;
	localparam logic [15:0] ROW_STRIDE_RST      = 16'd2560;
	localparam logic [2:0]  BYTES_PER_PIXEL_RST = 3'd4;

	localparam int PHASE_BITS_DEFAULT = 24;
	localparam int MAX_LINES          = 4096;

	// CORDIC: 16 rotations, angles in 2^32-per-turn units
	localparam int CORDIC_STAGES = 16;
	localparam int CORDIC_W      = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

	localparam logic [29:0] ATAN_TURNS [CORDIC_STAGES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861
	};

	// Per-pixel address fields that ride along the pipeline
	typedef struct packed {
		logic [11:0] row;
		logic [14:0] col_bytes;
		logic [27:0] dest;
	} item_t;

	// One CORDIC cell's worth of state plus the riding item
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [CORDIC_W-1:0] z;
		item_t                      item;
	} cordic_t;

endpackage

`default_nettype wire

/* rtl/swraddr_cordic_cell.sv */
// One CORDIC rotation cell with its own valid/ready pipeline register.
// Depends on swraddr_pkg.
`default_nettype none

module swraddr_cordic_cell #(
	parameter int STAGE = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  swraddr_pkg::cordic_t d_in,
	input  wire                  valid_in,
	output logic                 ready_out,
	output swraddr_pkg::cordic_t d_out,
	output logic                 valid_out,
	input  wire                  ready_in
);

	localparam logic signed [swraddr_pkg::CORDIC_W-1:0] ATAN =
		$signed(swraddr_pkg::CORDIC_W'(swraddr_pkg::ATAN_TURNS[STAGE]));

	swraddr_pkg::cordic_t nxt;
	swraddr_pkg::cordic_t data_q;
	logic                 valid_q;
	logic signed [swraddr_pkg::CORDIC_W-1:0] dx;
	logic signed [swraddr_pkg::CORDIC_W-1:0] dy;

	assign ready_out = !valid_q || ready_in;

	// floor shifts
	assign dx = d_in.y >>> STAGE;
	assign dy = d_in.x >>> STAGE;

	always_comb begin
		nxt = d_in;
		if (!d_in.z[swraddr_pkg::CORDIC_W-1]) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - ATAN;
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_out) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_out && valid_in) begin
			data_q <= nxt;
		end
	end

	assign d_out     = data_q;
	assign valid_out = valid_q;

endmodule

`default_nettype wire

/* rtl/sine_wave_row_warp_address_unit.sv */
// Top level of the sine-wave row warp address unit: front multipliers,
// the CORDIC cell chain and the row/offset back end. Depends on swraddr_pkg
// and swraddr_cordic_cell.
//
// For each transaction (pixel_row, pixel_col) the unit returns the
// destination byte offset, the source byte offset, the displaced source row
// and a copy flag. Source row = trunc(pixel_row + 20*sin(phase)), with
// phase = phase_step*pixel_col modulo one turn (PHASE_BITS-bit fraction),
// the sine in Q1.15 from a 16-cell CORDIC. Throughput is one transaction
// per clock while out_ready holds; a result passes through two front
// stages, sixteen CORDIC cells and four back-end stages. Every stage has
// its own valid bit and a ready that passes back down the chain, so bubbles
// fill and new input keeps flowing while a result waits on the output.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data and should
// only change while the pipeline is empty. Out-of-frame rows give
// copy_valid = 0 with source_row and source_offset forced to zero;
// offsets wrap modulo 2^28.
`default_nettype none

module sine_wave_row_warp_address_unit #(
	parameter int PHASE_BITS = swraddr_pkg::PHASE_BITS_DEFAULT
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_wr_en,
	input  wire  [swraddr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire  [swraddr_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [11:0]                          pixel_row,
	input  wire  [11:0]                          pixel_col,
	// output channel
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [27:0]                          dest_offset,
	output logic [27:0]                          source_offset,
	output logic [11:0]                          source_row,
	output logic                                 copy_valid
);

	localparam int ANG_SHIFT = 32 - PHASE_BITS;
	localparam int NC        = swraddr_pkg::CORDIC_STAGES;
	localparam int CW        = swraddr_pkg::CORDIC_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [23:0] phase_step_q;
	logic [12:0] frame_height_q;
	logic [15:0] row_stride_q;
	logic [2:0]  bytes_per_pixel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q      <= swraddr_pkg::PHASE_STEP_RST;
			frame_height_q    <= swraddr_pkg::FRAME_HEIGHT_RST;
			row_stride_q      <= swraddr_pkg::ROW_STRIDE_RST;
			bytes_per_pixel_q <= swraddr_pkg::BYTES_PER_PIXEL_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				swraddr_pkg::REG_PHASE_STEP:      phase_step_q      <= cfg_data[23:0];
				swraddr_pkg::REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[12:0];
				swraddr_pkg::REG_ROW_STRIDE:      row_stride_q      <= cfg_data[15:0];
				swraddr_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Ready chain: a stage takes new data when empty or when it drains
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	swraddr_pkg::cordic_t chain_d [NC+1];
	logic                 chain_v [NC+1];
	logic                 chain_r [NC+1];

	assign rdy_s6 = !v_s6 || out_ready;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || chain_r[0];
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// ------------------------------------------------------------------
	// s1: phase product and the two address products
	// ------------------------------------------------------------------
	logic [35:0]           phase_prod;
	logic [PHASE_BITS-1:0] phase_s1;
	logic [11:0]           row_s1;
	logic [27:0]           row_bytes_s1;
	logic [14:0]           col_bytes_s1;

	assign phase_prod = 36'(phase_step_q) * 36'(pixel_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			phase_s1     <= phase_prod[PHASE_BITS-1:0];
			row_s1       <= pixel_row;
			row_bytes_s1 <= 28'(pixel_row) * 28'(row_stride_q);
			col_bytes_s1 <= 15'(pixel_col) * 15'(bytes_per_pixel_q);
		end
	end

	// ------------------------------------------------------------------
	// s2: left-align the phase to a 32-bit turn, fold into +-90 degrees,
	// and finish the destination offset
	// ------------------------------------------------------------------
	logic [31:0]        angle;
	logic [31:0]        angle_rot;
	logic [31:0]        angle_s2;
	swraddr_pkg::item_t item_s2;

	assign angle     = 32'(phase_s1) << ANG_SHIFT;
	assign angle_rot = angle + 32'h4000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			angle_s2          <= angle_rot[31] ? (32'h8000_0000 - angle) : angle;
			item_s2.row       <= row_s1;
			item_s2.col_bytes <= col_bytes_s1;
			item_s2.dest      <= 28'(row_bytes_s1 + 28'(col_bytes_s1));
		end
	end

	// ------------------------------------------------------------------
	// CORDIC cell chain, one rotation per cell
	// ------------------------------------------------------------------
	// x, y, z, riding item
	assign chain_d[0]  = {swraddr_pkg::CORDIC_X0, CW'(0), CW'($signed(angle_s2)), item_s2};
	assign chain_v[0]  = v_s2;
	assign chain_r[NC] = rdy_s3;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		swraddr_cordic_cell #(
			.STAGE(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.d_in     (chain_d[i]),
			.valid_in (chain_v[i]),
			.ready_out(chain_r[i]),
			.d_out    (chain_d[i+1]),
			.valid_out(chain_v[i+1]),
			.ready_in (chain_r[i+1])
		);
	end

	// ------------------------------------------------------------------
	// s3: round y to Q1.15 and saturate
	// ------------------------------------------------------------------
	logic signed [CW-1:0] y_rnd;
	logic signed [CW-1:0] s_full;
	logic signed [15:0]   sine_sat;
	logic signed [15:0]   sine_s3;
	swraddr_pkg::item_t   item_s3;

	assign y_rnd  = chain_d[NC].y + CW'(16384);
	assign s_full = y_rnd >>> 15;

	always_comb begin
		if (s_full > CW'(32767)) begin
			sine_sat = 16'sh7fff;
		end else if (s_full < -CW'(32768)) begin
			sine_sat = -16'sh8000;
		end else begin
			sine_sat = s_full[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= chain_v[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && chain_v[NC]) begin
			sine_s3 <= sine_sat;
			item_s3 <= chain_d[NC].item;
		end
	end

	// ------------------------------------------------------------------
	// s4: row + 20*sine, truncate toward zero, range check
	// ------------------------------------------------------------------
	logic signed [20:0] wave;
	logic signed [28:0] total;
	logic signed [28:0] total_adj;
	logic signed [13:0] src;
	logic               src_ok;
	logic [12:0]        src_s4;
	logic               copy_s4;
	swraddr_pkg::item_t item_s4;

	assign wave      = 21'(sine_s3) * 21'sd20;
	assign total     = $signed({2'b00, item_s3.row, 15'b0}) + 29'(wave);
	assign total_adj = total + (total[28] ? 29'sd32767 : 29'sd0);
	assign src       = total_adj[28:15];
	assign src_ok    = !src[13] && (src[12:0] < frame_height_q)
	                   && (int'(src[12:0]) < swraddr_pkg::MAX_LINES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			src_s4  <= src_ok ? src[12:0] : 13'd0;
			copy_s4 <= src_ok;
			item_s4 <= item_s3;
		end
	end

	// ------------------------------------------------------------------
	// s5: source row times stride
	// ------------------------------------------------------------------
	logic [28:0]        src_prod;
	logic [27:0]        src_bytes_s5;
	logic [12:0]        src_s5;
	logic               copy_s5;
	swraddr_pkg::item_t item_s5;

	assign src_prod = 29'(src_s4) * 29'(row_stride_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			src_bytes_s5 <= src_prod[27:0];
			src_s5       <= src_s4;
			copy_s5      <= copy_s4;
			item_s5      <= item_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: output register
	// ------------------------------------------------------------------
	logic [27:0] dest_s6;
	logic [27:0] src_off_s6;
	logic [11:0] src_row_s6;
	logic        copy_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			dest_s6    <= item_s5.dest;
			src_off_s6 <= copy_s5 ? 28'(src_bytes_s5 + 28'(item_s5.col_bytes)) : 28'd0;
			src_row_s6 <= src_s5[11:0];
			copy_s6    <= copy_s5;
		end
	end

	assign out_valid     = v_s6;
	assign dest_offset   = dest_s6;
	assign source_offset = src_off_s6;
	assign source_row    = src_row_s6;
	assign copy_valid    = copy_s6;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// Input only backs up when the output is actually stalled
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without an output stall");

	// Rejected pixels carry zero source fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !copy_valid) |-> (source_row == 12'd0 && source_offset == 28'd0))
		else $error("rejected pixel with nonzero source fields");

	// Accepted pixels stay inside the frame
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && copy_valid) |-> ({1'b0, source_row} < frame_height_q))
		else $error("copied pixel outside the frame");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the sine-wave row warp address unit.
// Depends on swraddr_pkg (register indexes, config data width) and the unit's RTL.
`timescale 1ns / 100ps

module testbench;

	// ------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------
	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [swraddr_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [swraddr_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [11:0]                         pixel_row;
	logic [11:0]                         pixel_col;
	logic                                out_valid;
	logic                                out_ready;
	logic [27:0]                         dest_offset;
	logic [27:0]                         source_offset;
	logic [11:0]                         source_row;
	logic                                copy_valid;

	sine_wave_row_warp_address_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_row    (pixel_row),
		.pixel_col    (pixel_col),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.dest_offset  (dest_offset),
		.source_offset(source_offset),
		.source_row   (source_row),
		.copy_valid   (copy_valid)
	);

	// ------------------------------------------------------------------
	// Predictor: register shadow and the expected-address queue
	// ------------------------------------------------------------------
	typedef struct {
		logic [27:0] dest;
		logic [27:0] src;
		logic [11:0] row;
		logic        copy;
	} warp_addr_t;

	warp_addr_t  pending_addrs[$];

	logic [23:0] sh_phase_step;
	logic [12:0] sh_frame_height;
	logic [15:0] sh_row_stride;
	logic [2:0]  sh_bytes_per_pixel;

	int          mismatches;
	bit          quiet_in;     // sender offers back to back
	bit          quiet_out;    // receiver never stalls on its own
	int          hold_req;     // one-shot long stall request for the receiver

	// arctangent of 2^-i, in 2^32-per-turn units
	localparam longint ATAN_STEP [16] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331,  21354465,  10679838,  5340245,
		2670163,   1335087,   667544,    333772,
		166886,    83443,     41722,     20861
	};
	localparam longint GAIN_X0   = 652032874;
	localparam int     AMPLITUDE = 20;
	localparam int     LINE_CAP  = 4096;
	localparam int     DRAIN_CYC = 30;   // pipeline is 22 deep

	// Q1.15 sine of a 32-bit turn angle, 16 rotations, floor shifts
	function automatic longint sine_q15(input logic [31:0] turn_angle);
		logic [31:0] a;
		longint      x, y, z, dx, dy, s;
		a = turn_angle;
		// fold the left half plane onto the right: angle -> half turn - angle
		if (((a + 32'h4000_0000) & 32'h8000_0000) != 0)
			a = 32'h8000_0000 - a;
		z = longint'($signed(a));
		x = GAIN_X0;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_STEP[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_STEP[i];
			end
		end
		s = (y + 16384) >>> 15;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s;
	endfunction

	function automatic warp_addr_t warp_addresses(input logic [11:0] r, input logic [11:0] c);
		warp_addr_t  res;
		logic [35:0] turns;
		logic [31:0] angle;
		longint      sum, src, col_bytes, d;
		turns     = 36'(sh_phase_step) * 36'(c);
		angle     = {turns[23:0], 8'h00};
		sum       = longint'(r) * 32768 + longint'(AMPLITUDE) * sine_q15(angle);
		src       = sum / 32768;    // truncates toward zero
		col_bytes = longint'(c) * longint'(sh_bytes_per_pixel);
		d         = longint'(r) * longint'(sh_row_stride) + col_bytes;
		res.dest  = d[27:0];
		if (src >= 0 && src < longint'(sh_frame_height) && src < longint'(LINE_CAP)) begin
			d        = src * longint'(sh_row_stride) + col_bytes;
			res.src  = d[27:0];
			res.row  = src[11:0];
			res.copy = 1'b1;
		end else begin
			res.src  = '0;
			res.row  = '0;
			res.copy = 1'b0;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared helpers
	// ------------------------------------------------------------------
	// mostly short gaps, now and then a long one
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// One input transaction; called at a clock edge, returns at the accepting edge.
	task automatic send_pixel(input logic [11:0] r, input logic [11:0] c);
		int gap;
		gap = pick_gap(quiet_in);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel_row <= r;
		pixel_col <= c;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		pending_addrs.push_back(warp_addresses(r, c));
	endtask

	// Stop offering, let every expected transaction come out, then pad.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_addrs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Writes all four registers; junk fills the bits above each register's width.
	task automatic load_registers(input logic [23:0] ps, input logic [12:0] fh,
			input logic [15:0] rs, input logic [2:0] bpp, input bit junk);
		logic [swraddr_pkg::CFG_DATA_W-1:0] noise;
		logic [swraddr_pkg::CFG_DATA_W-1:0] value [4];
		logic [swraddr_pkg::CFG_INDEX_W-1:0] idx [4];
		idx[0] = swraddr_pkg::REG_PHASE_STEP;      value[0] = ps;
		idx[1] = swraddr_pkg::REG_FRAME_HEIGHT;    value[1] = {11'd0, fh};
		idx[2] = swraddr_pkg::REG_ROW_STRIDE;      value[2] = {8'd0, rs};
		idx[3] = swraddr_pkg::REG_BYTES_PER_PIXEL; value[3] = {21'd0, bpp};
		for (int i = 0; i < 4; i++) begin
			noise = junk ? swraddr_pkg::CFG_DATA_W'($urandom) : '0;
			case (idx[i])
				swraddr_pkg::REG_FRAME_HEIGHT:    noise[12:0] = '0;
				swraddr_pkg::REG_ROW_STRIDE:      noise[15:0] = '0;
				swraddr_pkg::REG_BYTES_PER_PIXEL: noise[2:0]  = '0;
				default:                          noise       = '0;
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= value[i] | noise;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		sh_phase_step      = ps;
		sh_frame_height    = fh;
		sh_row_stride      = rs;
		sh_bytes_per_pixel = bpp;
	endtask

	function automatic logic [11:0] pick_row();
		int lim;
		lim = int'(sh_frame_height) + 24;
		if (lim > 4095)
			lim = 4095;
		// half the rows land near the frame so both copy outcomes show up
		if ($urandom_range(0, 1))
			return 12'($urandom_range(0, lim));
		return 12'($urandom_range(0, 4095));
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset register values; quarter and three-quarter turn columns,
	// row 0 with a tiny negative wave, rows pushed past the frame and MAX_LINES.
	task automatic test_reset_defaults();
		send_pixel(12'd0,    12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0,    12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd100,  12'd32);
		send_pixel(12'd100,  12'd97);
		send_pixel(12'd479,  12'd32);
		send_pixel(12'd4095, 12'd33);
		send_pixel(12'd0,    12'd130);
		send_pixel(12'd10,   12'd98);
		send_pixel(12'd2048, 12'd2048);
	endtask

	task automatic test_register_extremes();
		// no wave, one-row frame, unit stride and pixel size
		settle();
		load_registers(24'd0, 13'd1, 16'd1, 3'd1, 1'b0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd1, 12'd100);
		// largest values: phase just under a full turn per column
		settle();
		load_registers(24'hFF_FFFF, 13'd4096, 16'hFFFF, 3'd7, 1'b0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0,    12'd4095);
		send_pixel(12'd20,   12'd1);
		// empty frame, zero stride and pixel size, quarter turn per column
		settle();
		load_registers(24'h40_0000, 13'd0, 16'd0, 3'd0, 1'b0);
		send_pixel(12'd100, 12'd1);
		send_pixel(12'd100, 12'd3);
		send_pixel(12'd0,   12'd2);
		// frame taller than MAX_LINES; rows near the top and bottom edges
		settle();
		load_registers(24'h40_0000, 13'd8191, 16'd2560, 3'd3, 1'b0);
		send_pixel(12'd4080, 12'd1);
		send_pixel(12'd4070, 12'd1);
		send_pixel(12'd5,    12'd3);
		send_pixel(12'd19,   12'd3);
		send_pixel(12'd20,   12'd3);
	endtask

	task automatic test_random_traffic();
		logic [23:0] ps;
		logic [12:0] fh;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case ($urandom_range(0, 3))
				0:       ps = 24'($urandom_range(0, 255));
				1:       ps = 24'($urandom);
				2:       ps = 24'(129052 + $urandom_range(0, 4095) - 2048);
				default: ps = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
			endcase
			fh = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191))
			                                 : 13'($urandom_range(1, 4096));
			if (ph == 5)
				load_registers(24'hFF_FFFF, 13'd8191, 16'hFFFF, 3'd7, 1'b1);
			else
				load_registers(ps, fh, 16'($urandom_range(0, 65535)),
					3'($urandom_range(0, 7)), 1'b1);
			// first phase runs with no idling on either side
			quiet_in  = (ph == 0);
			quiet_out = (ph == 0);
			for (int n = 0; n < 150; n++)
				send_pixel(pick_row(), 12'($urandom_range(0, 4095)));
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
	endtask

	// Receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_output_backpressure();
		settle();
		load_registers(24'd129052, 13'd480, 16'd2560, 3'd4, 1'b0);
		quiet_in = 1'b1;
		hold_req = 300;
		for (int n = 0; n < 100; n++)
			send_pixel(pick_row(), 12'($urandom_range(0, 4095)));
		quiet_in = 1'b0;
	endtask

	// Sender pauses until every result is out, then resumes.
	task automatic test_drain_pause();
		for (int n = 0; n < 40; n++)
			send_pixel(pick_row(), 12'($urandom_range(0, 4095)));
		in_valid <= 1'b0;
		while (pending_addrs.size() != 0)
			@(posedge clk);
		@(posedge clk);
		for (int n = 0; n < 40; n++)
			send_pixel(pick_row(), 12'($urandom_range(0, 4095)));
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and stimulus
	// ------------------------------------------------------------------
	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : stimulus
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		in_valid           = 1'b0;
		pixel_row          = '0;
		pixel_col          = '0;
		mismatches         = 0;
		quiet_in           = 1'b0;
		quiet_out          = 1'b0;
		hold_req           = 0;
		sh_phase_step      = 24'd129052;
		sh_frame_height    = 13'd480;
		sh_row_stride      = 16'd2560;
		sh_bytes_per_pixel = 3'd4;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_drain_pause();

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: random ready, long hold on request, checks each transaction
	// ------------------------------------------------------------------
	initial begin : result_monitor
		int         lull;
		warp_addr_t want;
		lull      = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_addrs.size() == 0) begin
					report_mismatch("unexpected transaction, dest_offset",
						longint'(dest_offset), -1);
				end else begin
					want = pending_addrs.pop_front();
					if (dest_offset !== want.dest)
						report_mismatch("dest_offset", longint'(dest_offset),
							longint'(want.dest));
					if (source_offset !== want.src)
						report_mismatch("source_offset", longint'(source_offset),
							longint'(want.src));
					if (source_row !== want.row)
						report_mismatch("source_row", longint'(source_row),
							longint'(want.row));
					if (copy_valid !== want.copy)
						report_mismatch("copy_valid", longint'(copy_valid),
							longint'(want.copy));
				end
			end
			if (hold_req > 0) begin
				lull     = hold_req;
				hold_req = 0;
			end
			if (lull > 0) begin
				out_ready <= 1'b0;
				lull--;
			end else begin
				out_ready <= 1'b1;
				lull = pick_gap(quiet_out);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin : watchdog
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
